// ===== design/accel_step_detector_defines.svh =====
// ----------------------------------------------------------------------------
// accel_step_detector_defines
// assertion macros shared by the step detector rtl
// ----------------------------------------------------------------------------
`ifndef ACCEL_STEP_DETECTOR_DEFINES_SVH
`define ACCEL_STEP_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define ASD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define ASD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/asd_pkg.sv =====
// ----------------------------------------------------------------------------
// asd_pkg
// types and constants for the accelerometer step detector
// ----------------------------------------------------------------------------
package asd_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_HIGH_THR = 2'd0;
  localparam logic [1:0] REG_LOW_THR  = 2'd1;
  localparam logic [1:0] REG_DEBOUNCE = 2'd2;

  localparam logic [15:0] HIGH_THR_RST = 16'd24576;
  localparam logic [15:0] LOW_THR_RST  = 16'd18022;
  localparam logic [15:0] DEBOUNCE_RST = 16'd250;

  // numerator of the cadence division, ms per minute
  localparam logic [15:0] CADENCE_NUM = 16'd60000;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } srl_stat_t;

endpackage

// ===== design/asd_sqr.sv =====
// ----------------------------------------------------------------------------
// asd_sqr
// bit-serial squarer: one shift-add step per cycle, one step per bit of the operand
// ----------------------------------------------------------------------------
module asd_sqr import asd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] operand_i,
  output srl_stat_t   stat_o,
  output logic [31:0] product_o
);

  logic [15:0] a_q;
  logic [31:0] p_q;
  logic [3:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [16:0] add;

  // partial sum of the upper half, multiplier bit sits at p_q[0]
  assign add = {1'b0, p_q[31:16]} + (p_q[0] ? {1'b0, a_q} : 17'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= operand_i;
      p_q <= {16'd0, operand_i};
    end else if (busy_q) begin
      p_q <= {add, p_q[15:1]};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign product_o   = p_q;

endmodule

// ===== design/asd_div.sv =====
// ----------------------------------------------------------------------------
// asd_div
// restoring divider for the cadence, one quotient bit per cycle
// ----------------------------------------------------------------------------
module asd_div import asd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] divisor_i,
  output srl_stat_t   stat_o,
  output logic [15:0] quotient_o
);

  logic [31:0] div_q;
  logic [15:0] rem_q;
  logic [15:0] quo_q;
  logic [3:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  // quo_q shifts dividend bits out at the top and quotient bits in at the bottom
  assign trial = {rem_q, quo_q[15]};
  assign ge    = {15'd0, trial} >= div_q;
  assign diff  = trial - div_q[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= CADENCE_NUM;
    end else if (busy_q) begin
      // remainder never exceeds the dividend, so 16 bits hold it
      rem_q <= ge ? diff[15:0] : trial[15:0];
      quo_q <= {quo_q[14:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

// ===== design/accel_step_detector.sv =====
// ----------------------------------------------------------------------------
// accel_step_detector
// step detection with hysteresis on a three-axis accelerometer stream
// ----------------------------------------------------------------------------
// One input beat carries one sample (x, y, z, timestamp in ms); every
// sample gives exactly one output beat (step flag, cadence, above flag).
// The squared magnitude and the squared thresholds come out of one
// bit-serial squarer, five operands in turn; the cadence 60000 / interval
// comes from a bit-serial divider, run only when a step with a valid
// interval is reported. One sample is processed at a time, and the
// input takes no new beat until the core has loaded the last result.
// The result sits in an output register; the next sample is accepted
// while it waits, and a finished result only holds up the core when the
// previous one has not been taken yet.
// Configuration writes are taken on cfg_we_i and are meant to be made
// while no sample is in flight. Reset loads the default thresholds
// and debounce time, clears the above flag and both step times and
// empties the output register.
// ----------------------------------------------------------------------------
module accel_step_detector import asd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // accel_x [15:0], accel_y [31:16], accel_z [47:32], time_ms [79:48]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // step_detected [0], cadence [16:1], is_above [17], zero [23:18]
  output logic [23:0] m_axis_tdata
);

`include "accel_step_detector_defines.svh"

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQR  = 5'b00010,
    ST_CMP  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] high_thr_q, low_thr_q, debounce_q;
  logic        above_q, above_d;
  logic [31:0] last_q, last_d;
  logic [31:0] prev_q, prev_d;

  logic [15:0] x_q, y_q, z_q;
  logic [31:0] time_q;
  logic [2:0]  idx_q, idx_d;
  logic [31:0] sum_q, sum_d;
  logic [31:0] hi_sq_q, hi_sq_d;
  logic [31:0] lo_sq_q, lo_sq_d;

  logic        res_step_q, res_step_d;
  logic [15:0] res_cad_q, res_cad_d;
  logic        res_above_q, res_above_d;

  logic        out_valid_q, out_valid_d;
  logic [23:0] out_data_q;
  logic        out_load;

  logic        in_fire;
  logic        sqr_start;
  logic [15:0] sqr_op;
  logic [2:0]  sqr_sel;
  srl_stat_t   sqr_stat;
  logic [31:0] sqr_prod;

  logic        div_start;
  logic [31:0] div_den;
  srl_stat_t   div_stat;
  logic [15:0] div_quo;

  logic [31:0] elapsed;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_thr_q <= HIGH_THR_RST;
      low_thr_q  <= LOW_THR_RST;
      debounce_q <= DEBOUNCE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HIGH_THR: high_thr_q <= cfg_data_i;
        REG_LOW_THR:  low_thr_q  <= cfg_data_i;
        REG_DEBOUNCE: debounce_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // operand select: |x|, |y|, |z|, high, low
  always_comb begin
    case (sqr_sel)
      3'd0:    sqr_op = x_q[15] ? (~x_q + 16'd1) : x_q;
      3'd1:    sqr_op = y_q[15] ? (~y_q + 16'd1) : y_q;
      3'd2:    sqr_op = z_q[15] ? (~z_q + 16'd1) : z_q;
      3'd3:    sqr_op = high_thr_q;
      3'd4:    sqr_op = low_thr_q;
      default: sqr_op = '0;
    endcase
  end

  assign elapsed = time_q - last_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    hi_sq_d     = hi_sq_q;
    lo_sq_d     = lo_sq_q;
    above_d     = above_q;
    last_d      = last_q;
    prev_d      = prev_q;
    res_step_d  = res_step_q;
    res_cad_d   = res_cad_q;
    res_above_d = res_above_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;
    sqr_start   = 1'b0;
    sqr_sel     = idx_q;
    div_start   = 1'b0;
    div_den     = last_q - prev_q;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          // the first operand comes from the input regs loaded this edge
          idx_d   = 3'd0;
          sum_d   = '0;
          state_d = ST_SQR;
        end
      end
      ST_SQR: begin
        if (!sqr_stat.busy && !sqr_stat.done) begin
          sqr_start = 1'b1;
        end else if (sqr_stat.done) begin
          case (idx_q)
            3'd3:    hi_sq_d = sqr_prod;
            3'd4:    lo_sq_d = sqr_prod;
            default: sum_d   = sum_q + sqr_prod;
          endcase
          if (idx_q == 3'd4) begin
            state_d = ST_CMP;
          end else begin
            idx_d     = idx_q + 3'd1;
            sqr_sel   = idx_q + 3'd1;
            sqr_start = 1'b1;
          end
        end
      end
      ST_CMP: begin
        res_step_d = 1'b0;
        res_cad_d  = '0;
        state_d    = ST_DONE;
        if (!above_q && (sum_q > hi_sq_q)) begin
          above_d = 1'b1;
          if (elapsed >= {16'd0, debounce_q}) begin
            res_step_d = 1'b1;
            prev_d     = last_q;
            last_d     = time_q;
            // interval only counts when the earlier step time is nonzero and the two are ordered
            if ((prev_q != '0) && (last_q > prev_q)) begin
              div_start = 1'b1;
              state_d   = ST_DIV;
            end
          end
        end else if (above_q && (sum_q < lo_sq_q)) begin
          above_d = 1'b0;
        end
        res_above_d = above_d;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          res_cad_d = div_quo;
          state_d   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      above_q     <= 1'b0;
      last_q      <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      above_q     <= above_d;
      last_q      <= last_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q    <= s_axis_tdata[15:0];
      y_q    <= s_axis_tdata[31:16];
      z_q    <= s_axis_tdata[47:32];
      time_q <= s_axis_tdata[79:48];
    end
    idx_q       <= idx_d;
    sum_q       <= sum_d;
    hi_sq_q     <= hi_sq_d;
    lo_sq_q     <= lo_sq_d;
    res_step_q  <= res_step_d;
    res_cad_q   <= res_cad_d;
    res_above_q <= res_above_d;
    if (out_load) begin
      out_data_q <= {6'd0, res_above_q, res_cad_q, res_step_q};
    end
  end

  asd_sqr u_sqr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqr_start),
    .operand_i (sqr_op),
    .stat_o    (sqr_stat),
    .product_o (sqr_prod)
  );

  asd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (div_den),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `ASD_ASSERT_NXT(a_busy_after_accept, in_fire, !s_axis_tready, "input taken while busy")
  `ASD_ASSERT_IMP(a_step_implies_above, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[17],
    "step reported without above flag")
  `ASD_ASSERT_IMP(a_cadence_needs_step, m_axis_tvalid && (m_axis_tdata[16:1] != 16'd0),
    m_axis_tdata[0], "cadence without a step")
  `ASD_ASSERT_IMP(a_div_only_in_div, div_stat.busy, state_q == ST_DIV,
    "divider running outside its state")

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench for the accelerometer step detector
// ----------------------------------------------------------------------------
// Samples go in on the input stream and a local model of the hysteresis,
// debounce and cadence logic predicts one result for every accepted beat.
// Each output beat is checked field by field against the oldest prediction.
// Directed samples cover the threshold edges, debounce, timestamp wrap and
// the register extremes. After that, random walking sequences mixed with
// noise and timestamp jumps run under several idle and stall mixes and
// register settings, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import asd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 1000;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam int unsigned MAX_REPORTS  = 40;

  // input beat, last field in the low bits
  typedef struct packed {
    logic [31:0]        t_ms;
    logic signed [15:0] az;
    logic signed [15:0] ay;
    logic signed [15:0] ax;
  } sample_t;

  // output beat, low 18 bits
  typedef struct packed {
    logic        above;
    logic [15:0] cadence;
    logic        step;
  } stride_t;

  typedef enum logic [1:0] {MAG_HIGH, MAG_MID, MAG_LOW, MAG_NOISE} mag_kind_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = REG_HIGH_THR;
  logic [15:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  // step tracker state and register copies
  logic        above_st       = 1'b0;
  logic [31:0] latest_step_ms = '0;
  logic [31:0] earlier_step_ms = '0;
  logic [15:0] hi_thr         = HIGH_THR_RST;
  logic [15:0] lo_thr         = LOW_THR_RST;
  logic [15:0] debounce_ms    = DEBOUNCE_RST;

  stride_t     stride_q[$];
  int unsigned err_cnt       = 0;
  int unsigned items_sent    = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned src_idle_pct  = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_left     = 0;
  logic        hold_start    = 1'b0;
  logic [31:0] now_ms        = '0;

  accel_step_detector dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // long output hold-off, counted on its own
  always @(posedge clk_i) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
  end

  function automatic void note_mismatch(string what, int unsigned want, int unsigned seen);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, seen);
  endfunction

  always @(posedge clk_i) begin : check_beats
    stride_t want;
    stride_t seen;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata[17:0];
      if (stride_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: unexpected result beat, expected none, got 0x%06h",
                   $time, m_axis_tdata);
      end else begin
        want = stride_q.pop_front();
        if (seen.step != want.step)
          note_mismatch("step_detected", 32'(want.step), 32'(seen.step));
        if (seen.cadence != want.cadence)
          note_mismatch("cadence", 32'(want.cadence), 32'(seen.cadence));
        if (seen.above != want.above)
          note_mismatch("is_above", 32'(want.above), 32'(seen.above));
        if (m_axis_tdata[23:18] != '0)
          note_mismatch("pad bits", 32'd0, 32'(m_axis_tdata[23:18]));
      end
    end
  end

  // hysteresis, debounce and cadence for one sample; updates the tracker state
  function automatic stride_t predict_stride(sample_t s);
    longint      mag;
    longint      hi_sq;
    longint      lo_sq;
    logic [31:0] since_last;
    logic [31:0] span;
    stride_t     r;
    mag = longint'(s.ax) * longint'(s.ax) + longint'(s.ay) * longint'(s.ay)
        + longint'(s.az) * longint'(s.az);
    hi_sq = longint'(hi_thr) * longint'(hi_thr);
    lo_sq = longint'(lo_thr) * longint'(lo_thr);
    r = '0;
    if (!above_st && mag > hi_sq) begin
      above_st = 1'b1;
      // elapsed time wraps modulo 2^32
      since_last = s.t_ms - latest_step_ms;
      if (since_last >= {16'd0, debounce_ms}) begin
        if (earlier_step_ms != '0 && latest_step_ms > earlier_step_ms) begin
          span = latest_step_ms - earlier_step_ms;
          r.cadence = 16'({16'd0, CADENCE_NUM} / span);
        end
        earlier_step_ms = latest_step_ms;
        latest_step_ms  = s.t_ms;
        r.step = 1'b1;
      end
    end else if (above_st && mag < lo_sq) begin
      above_st = 1'b0;
    end
    r.above = above_st;
    return r;
  endfunction

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= s;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    stride_q.push_back(predict_stride(s));
    items_sent++;
  endtask

  task automatic send_xyz(input int x, input int y, input int z, input logic [31:0] t);
    sample_t s;
    s.ax   = 16'(x);
    s.ay   = 16'(y);
    s.az   = 16'(z);
    s.t_ms = t;
    send_sample(s);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (stride_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_HIGH_THR: hi_thr = val;
      REG_LOW_THR:  lo_thr = val;
      REG_DEBOUNCE: debounce_ms = val;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [15:0] hi, input logic [15:0] lo,
                           input logic [15:0] deb);
    drain_results();
    write_reg(REG_HIGH_THR, hi);
    write_reg(REG_LOW_THR, lo);
    write_reg(REG_DEBOUNCE, deb);
  endtask

  task automatic set_idling(input int unsigned idle_pct, input int unsigned stall_pct);
    src_idle_pct  <= idle_pct;
    snk_stall_pct <= stall_pct;
    @(posedge clk_i);
  endtask

  // random axis value with its magnitude in a range, 32768 meaning full negative
  function automatic logic signed [15:0] rand_axis(int unsigned lo_abs, int unsigned hi_abs);
    int unsigned mag_abs;
    mag_abs = $urandom_range(hi_abs > 32768 ? 32768 : hi_abs,
                             lo_abs > 32768 ? 32768 : lo_abs);
    if (mag_abs >= 32768) return 16'sh8000;
    return $urandom_range(1) ? 16'(0 - mag_abs) : 16'(mag_abs);
  endfunction

  function automatic sample_t make_sample(mag_kind_e kind, logic [31:0] t);
    sample_t     s;
    int unsigned lo_b;
    int unsigned hi_b;
    lo_b = 32'((lo_thr < hi_thr) ? lo_thr : hi_thr);
    hi_b = 32'((lo_thr < hi_thr) ? hi_thr : lo_thr);
    s.t_ms = t;
    case (kind)
      MAG_HIGH: begin
        if (hi_thr < 16'd32767) begin
          s.ax = rand_axis(32'(hi_thr) + 32'd1, 32768);
          s.ay = rand_axis(0, 32'(hi_thr / 16'd4));
          s.az = rand_axis(0, 32'(hi_thr / 16'd4));
        end else begin
          // push all three axes near full scale, the most that can get above it
          s.ax = rand_axis(30000, 32768);
          s.ay = rand_axis(30000, 32768);
          s.az = rand_axis(30000, 32768);
        end
      end
      MAG_MID: begin
        s.ax = rand_axis(lo_b, hi_b);
        s.ay = '0;
        s.az = '0;
      end
      MAG_LOW: begin
        s.ax = rand_axis(0, 32'(lo_thr / 16'd2));
        s.ay = rand_axis(0, 32'(lo_thr / 16'd2));
        s.az = rand_axis(0, 32'(lo_thr / 16'd2));
      end
      default: begin
        s.ax = 16'($urandom());
        s.ay = 16'($urandom());
        s.az = 16'($urandom());
      end
    endcase
    // move the dominant axis around
    case ($urandom_range(2))
      1: {s.ax, s.ay, s.az} = {s.ay, s.az, s.ax};
      2: {s.ax, s.ay, s.az} = {s.az, s.ax, s.ay};
      default: ;
    endcase
    return s;
  endfunction

  // one sample of a walk, now and then noise or a timestamp jump
  task automatic emit(input mag_kind_e kind, input int unsigned dt);
    if ($urandom_range(99) < 8) kind = MAG_NOISE;
    if ($urandom_range(99) < 3) now_ms = $urandom();
    else now_ms += dt;
    send_sample(make_sample(kind, now_ms));
  endtask

  // impact, maybe a sample between thresholds, then release
  task automatic walk_step();
    int unsigned dt;
    dt = $urandom_range(60, 5);
    repeat ($urandom_range(3, 1)) emit(MAG_HIGH, dt);
    if ($urandom_range(3) == 0) emit(MAG_MID, dt);
    repeat ($urandom_range(4, 1)) emit(MAG_LOW, dt);
  endtask

  task automatic pick_random_config();
    logic [15:0] hi;
    logic [15:0] lo;
    logic [15:0] deb;
    hi = 16'($urandom_range(30000, 6000));
    case ($urandom_range(9))
      0: lo = 16'($urandom());
      1: lo = hi;
      default: lo = 16'($urandom_range(hi - 1, hi / 3));
    endcase
    deb = ($urandom_range(9) == 0) ? 16'($urandom()) : 16'($urandom_range(400));
    write_cfg(hi, lo, deb);
  endtask

  task automatic test_directed();
    // full-scale impact right after reset, still inside debounce from time 0
    send_xyz(-32768, -32768, -32768, 32'd100);
    send_xyz(0, 0, 0, 32'd200);
    // first step, no interval yet
    send_xyz(32767, 0, 0, 32'd300);
    send_xyz(21000, 0, 0, 32'd310);
    send_xyz(0, 0, 0, 32'd320);
    // rising edge inside debounce
    send_xyz(24577, 0, 0, 32'd400);
    send_xyz(18021, 0, 0, 32'd420);
    // exactly on the high threshold is not above it
    send_xyz(24576, 0, 0, 32'd900);
    send_xyz(0, -24577, 0, 32'd900);
    send_xyz(0, 0, 0, 32'd950);
    send_xyz(0, 0, 32767, 32'hFFFF_FE00);
    send_xyz(0, 0, 0, 32'hFFFF_FE10);
    // elapsed time across the timestamp wrap
    send_xyz(0, 0, -30000, 32'h0000_0100);
    send_xyz(0, 0, 0, 32'h0000_0110);
    send_xyz(30000, 30000, 30000, 32'h0000_0500);
  endtask

  task automatic test_cfg_extremes();
    write_cfg(16'd0, 16'd0, 16'd0);
    send_xyz(0, 0, 0, 32'd1000);
    // no debounce, steps one ms apart and in the same ms
    write_cfg(16'd100, 16'd50, 16'd0);
    send_xyz(0, 0, 0, 32'd2000);
    send_xyz(200, 0, 0, 32'd2000);
    send_xyz(0, 0, 0, 32'd2000);
    send_xyz(0, 200, 0, 32'd2001);
    send_xyz(0, 0, 0, 32'd2001);
    send_xyz(0, 0, -200, 32'd2002);
    send_xyz(0, 0, 0, 32'd2002);
    send_xyz(-200, 0, 0, 32'd2002);
    write_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_xyz(-32768, -32768, -32768, 32'd3000);
    // release threshold above the impact threshold
    write_cfg(16'd1000, 16'd40000, 16'hFFFF);
    send_xyz(2000, 0, 0, 32'd70000);
    send_xyz(2000, 0, 0, 32'd70010);
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    write_cfg(HIGH_THR_RST, LOW_THR_RST, DEBOUNCE_RST);
    now_ms = $urandom();
    hold_start <= 1'b1;
    @(posedge clk_i);
    hold_start <= 1'b0;
    repeat (4) walk_step();
  endtask

  task automatic test_random_walk(input int unsigned idle_pct, input int unsigned stall_pct,
                                  input int unsigned n_items);
    int unsigned target;
    set_idling(idle_pct, stall_pct);
    repeat (2) begin
      pick_random_config();
      now_ms = $urandom();
      target = items_sent + n_items / 2;
      while (items_sent < target) walk_step();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_cfg_extremes();
    test_backpressure();
    test_random_walk(0, 0, 270);
    test_random_walk(58, 0, 270);
    test_random_walk(0, 58, 270);
    test_random_walk(14, 14, 270);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/asd_pkg.sv
design/asd_sqr.sv
design/asd_div.sv
design/accel_step_detector.sv
sim/tb_top.sv
